// ----- hdl/ddo_pkg.sv -----
// Shared types, constants and helpers for the odometry block.
package ddo_pkg;

	localparam int TRIG_STEPS_DEF = 16;
	localparam int POS_FRAC_DEF   = 16;
	localparam int ATAN_N         = 28;

	localparam logic [31:0] PI_Q28       = 32'd843314857;
	localparam logic [31:0] TWO_PI_Q28   = 32'd1686629713;
	localparam logic [31:0] HALF_PI_Q28  = 32'd421657428;
	localparam logic [31:0] CORDIC_K_Q28 = 32'd163008219;
	localparam logic [31:0] DIST_K       = 32'd1978100247;
	// PI_Q28 = 180 * DEG_QUO + DEG_REM; small part divided by 180 via DEG_RECIP >> DEG_RSH
	localparam logic [31:0] DEG_QUO      = 32'd4685082;
	localparam logic [15:0] DEG_REM      = 16'd97;
	localparam logic [15:0] DEG_HALF     = 16'd90;
	localparam logic [31:0] DEG_RECIP    = 32'd46604;
	localparam int          DEG_RSH      = 23;
	localparam logic [31:0] USEC_PER_S   = 32'd1000000;

	localparam logic [15:0] GAIN_RST = 16'd4096;
	localparam logic [19:0] DIAM_RST = 20'd100000;

	typedef enum logic [2:0] {
		REG_LIN_FWD,
		REG_LIN_REV,
		REG_ANG_POS,
		REG_ANG_NEG,
		REG_DIAM
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_SD,
		ST_MUL_DIAM,
		ST_MUL_K,
		ST_MUL_LG,
		ST_MUL_DEG,
		ST_DIV_180,
		ST_MUL_AG,
		ST_DIV_RED1,
		ST_COR1,
		ST_MUL_DX,
		ST_MUL_DY,
		ST_DIV_RED2,
		ST_COR2,
		ST_MUL_CTDX,
		ST_MUL_STDY,
		ST_MUL_STDX,
		ST_MUL_CTDY,
		ST_MUL_LV,
		ST_DIV_LV,
		ST_MUL_AV,
		ST_DIV_AV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic   go;
		logic   load;
		logic   out_load;
		state_t step;
	} ddo_cmd_t;

	typedef struct packed {
		logic done;
	} ddo_stat_t;

	function automatic logic [31:0] atan_q28(input logic [4:0] i);
		case (i)
			5'd0:  return 32'd210828714;
			5'd1:  return 32'd124459457;
			5'd2:  return 32'd65760959;
			5'd3:  return 32'd33381290;
			5'd4:  return 32'd16755422;
			5'd5:  return 32'd8385879;
			5'd6:  return 32'd4193963;
			5'd7:  return 32'd2097109;
			5'd8:  return 32'd1048571;
			5'd9:  return 32'd524287;
			5'd10: return 32'd262144;
			5'd11: return 32'd131072;
			5'd12: return 32'd65536;
			5'd13: return 32'd32768;
			5'd14: return 32'd16384;
			5'd15: return 32'd8192;
			5'd16: return 32'd4096;
			5'd17: return 32'd2048;
			5'd18: return 32'd1024;
			5'd19: return 32'd512;
			5'd20: return 32'd256;
			5'd21: return 32'd128;
			5'd22: return 32'd64;
			5'd23: return 32'd32;
			5'd24: return 32'd16;
			5'd25: return 32'd8;
			5'd26: return 32'd4;
			5'd27: return 32'd2;
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input logic neg);
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return 32'(v);
	endfunction

endpackage

// ----- hdl/ddo_upd_if.sv -----
// Update channel: wheel speeds, elapsed time and gyro yaw.
interface ddo_upd_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_rpm;
	logic signed [15:0] right_rpm;
	logic        [19:0] step_time_us;
	logic signed [9:0]  yaw_degrees;

	modport source(output valid, left_rpm, right_rpm, step_time_us, yaw_degrees, input ready);
	modport sink(input valid, left_rpm, right_rpm, step_time_us, yaw_degrees, output ready);
endinterface

// ----- hdl/ddo_pose_if.sv -----
// Result channel: pose, velocities and stopped flag.
interface ddo_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading;
	logic signed [31:0] lin_vel;
	logic signed [31:0] ang_vel;
	logic               stopped;

	modport source(output valid, pos_x, pos_y, heading, lin_vel, ang_vel, stopped, input ready);
	modport sink(input valid, pos_x, pos_y, heading, lin_vel, ang_vel, stopped, output ready);
endinterface

// ----- hdl/ddo_cfg_if.sv -----
// Configuration write channel.
interface ddo_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [19:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/ddo_mul.sv -----
// Shift-add multiplier, 64 x 32 bits, one multiplier bit per cycle.
module ddo_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [31:0] b,
	output logic [95:0] prod,
	output logic        done
);
	logic [96:0] p_q;
	logic [63:0] a_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] hsum;

	assign hsum = p_q[96:32] + (p_q[0] ? {1'b0, a_q} : 65'd0);
	assign prod = p_q[95:0];
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {65'd0, b};
		end else if (busy_q) begin
			p_q <= {1'b0, hsum, p_q[31:1]};
		end
	end
endmodule

// ----- hdl/ddo_div.sv -----
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module ddo_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [63:0] quo,
	output logic        done
);
	logic [63:0] n_q;
	logic [31:0] r_q;
	logic [31:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;

	assign shifted = {r_q, n_q[63]};
	assign ge      = shifted >= {1'b0, d_q};
	assign diff    = shifted - {1'b0, d_q};
	assign quo     = n_q;
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			n_q <= {n_q[62:0], ge};
			r_q <= ge ? diff[31:0] : shifted[31:0];
		end
	end
endmodule

// ----- hdl/ddo_cordic.sv -----
// Iterative CORDIC: cos and sin of a reduced Q28 angle, one step per cycle, Q24 out.
module ddo_cordic
	import ddo_pkg::*;
#(
	parameter int TRIG_STEPS = TRIG_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] ang,
	output logic signed [31:0] cos_q24,
	output logic signed [31:0] sin_q24,
	output logic               done
);
	localparam int IW = $clog2(TRIG_STEPS);
	localparam logic signed [33:0] PI_S   = $signed({2'b00, PI_Q28});
	localparam logic signed [33:0] TWO_S  = $signed({2'b00, TWO_PI_Q28});
	localparam logic signed [33:0] HALF_S = $signed({2'b00, HALF_PI_Q28});
	localparam logic signed [33:0] K_S    = $signed({2'b00, CORDIC_K_Q28});

	logic signed [33:0] x_q, y_q, r_q;
	logic               neg_q;
	logic [IW-1:0]      i_q;
	logic               busy_q;
	logic               done_q;

	logic signed [33:0] a0, a1, a2, a3;
	logic               fold_neg;
	logic signed [33:0] at;
	logic signed [33:0] xs, ys;
	logic signed [33:0] xo, yo;

	function automatic logic signed [31:0] rnd4(input logic signed [33:0] v);
		logic [33:0] m;
		m = v[33] ? 34'(-v) : 34'(v);
		m = (m + 34'd8) >> 4;
		return v[33] ? -$signed(32'(m)) : $signed(32'(m));
	endfunction

	always_comb begin
		a0 = 34'(ang);
		a1 = (a0 > PI_S) ? a0 - TWO_S : a0;
		a2 = (a1 < -PI_S) ? a1 + TWO_S : a1;
		fold_neg = 1'b0;
		if (a2 > HALF_S) begin
			a3 = a2 - PI_S;
			fold_neg = 1'b1;
		end else if (a2 < -HALF_S) begin
			a3 = a2 + PI_S;
			fold_neg = 1'b1;
		end else begin
			a3 = a2;
		end
	end

	assign at = $signed({2'b00, atan_q28(5'(i_q))});
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign xo = neg_q ? -x_q : x_q;
	assign yo = neg_q ? -y_q : y_q;
	assign cos_q24 = rnd4(xo);
	assign sin_q24 = rnd4(yo);
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IW'(TRIG_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= K_S;
			y_q   <= '0;
			r_q   <= a3;
			neg_q <= fold_neg;
		end else if (busy_q) begin
			if (!r_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				r_q <= r_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				r_q <= r_q + at;
			end
		end
	end
endmodule

// ----- hdl/ddo_dp.sv -----
// Datapath: operand registers, shared multiplier, divider and CORDIC, pose state.
module ddo_dp
	import ddo_pkg::*;
#(
	parameter int TRIG_STEPS    = TRIG_STEPS_DEF,
	parameter int POS_FRAC_BITS = POS_FRAC_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ddo_cmd_t           cmd,
	output ddo_stat_t          stat,
	input  logic signed [15:0] left_rpm,
	input  logic signed [15:0] right_rpm,
	input  logic        [19:0] step_time_us,
	input  logic signed [9:0]  yaw_degrees,
	input  logic               cfg_we,
	input  logic        [2:0]  cfg_index,
	input  logic        [19:0] cfg_data,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [31:0] lin_vel,
	output logic signed [31:0] ang_vel,
	output logic               stopped
);
	localparam int RS = 48 - POS_FRAC_BITS;
	localparam logic signed [63:0] TWO_S = $signed(64'(TWO_PI_Q28));
	// quotient of the 2*pi reduction stays below 64
	localparam logic [2:0] RED_TOP = 3'd5;

	logic signed [16:0] sum_q;
	logic        [19:0] dt_q;
	logic signed [9:0]  deg_q;
	logic               stop_q;
	logic        [63:0] t_q;
	logic signed [63:0] dxy_q, dth_q, dx_q, dy_q, p1_q;
	logic signed [31:0] red_q, cd_q, sd_q, ct_q, st_q, lv_q, av_q;
	logic signed [31:0] acc_x_q, acc_y_q, acc_h_q;
	logic        [15:0] g_lf_q, g_lr_q, g_ap_q, g_an_q;
	logic        [19:0] diam_q;
	logic signed [31:0] pos_x_q, pos_y_q, heading_q, lin_vel_q, ang_vel_q;
	logic               stopped_q;

	logic               mul_start, div_start, cor_start, red_start;
	logic        [63:0] mul_a;
	logic        [31:0] mul_b;
	logic        [63:0] div_num;
	logic        [31:0] div_den;
	logic        [63:0] red_in;
	logic               rneg;
	logic        [95:0] prod;
	logic        [63:0] quo;
	logic               mul_done, div_done, cor_done;
	logic signed [31:0] cor_c, cor_s;

	logic               red_busy_q, red_done_q;
	logic        [2:0]  red_k_q;
	logic        [63:0] red_m_q;
	logic        [63:0] red_sub;
	logic signed [63:0] red_s;

	logic        [16:0] sum_abs;
	logic        [9:0]  deg_abs;
	logic        [15:0] deg_lo;
	logic        [63:0] k_hi, dist_m, gain_m, rot_m, rv_m;
	logic signed [63:0] mprod_s, quo_s, rv, rv_r, acc_sum, nh0, nh1, nh2;
	logic signed [31:0] acc_sel;
	logic        [31:0] dt_sh;

	assign sum_abs = sum_q[16] ? 17'(-sum_q) : 17'(sum_q);
	assign deg_abs = deg_q[9] ? 10'(-deg_q) : 10'(deg_q);
	assign deg_lo  = 16'(deg_abs) * DEG_REM + DEG_HALF;
	assign dt_sh   = {dt_q, 12'd0};

	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		cor_start = 1'b0;
		red_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_num   = '0;
		div_den   = '0;
		red_in    = '0;
		rneg      = 1'b0;
		case (cmd.step)
			ST_MUL_SD: begin
				mul_start = cmd.go;
				mul_a = 64'(sum_abs);
				mul_b = 32'(dt_q);
			end
			ST_MUL_DIAM: begin
				mul_start = cmd.go;
				mul_a = t_q;
				mul_b = 32'(diam_q);
			end
			ST_MUL_K: begin
				mul_start = cmd.go;
				mul_a = t_q;
				mul_b = DIST_K;
			end
			ST_MUL_LG: begin
				mul_start = cmd.go;
				mul_a = abs64(dxy_q);
				mul_b = 32'(dxy_q[63] ? g_lr_q : g_lf_q);
			end
			ST_MUL_DEG: begin
				mul_start = cmd.go;
				mul_a = 64'(deg_abs);
				mul_b = DEG_QUO;
			end
			ST_DIV_180: begin
				mul_start = cmd.go;
				mul_a = 64'(deg_lo);
				mul_b = DEG_RECIP;
				rneg = deg_q[9];
			end
			ST_MUL_AG: begin
				mul_start = cmd.go;
				mul_a = abs64(dth_q);
				mul_b = 32'(dth_q[63] ? g_an_q : g_ap_q);
			end
			ST_DIV_RED1: begin
				red_start = cmd.go;
				red_in = abs64(dth_q);
				rneg = dth_q[63];
			end
			ST_COR1: cor_start = cmd.go;
			ST_MUL_DX: begin
				mul_start = cmd.go;
				mul_a = abs64(dxy_q);
				mul_b = abs32(cd_q);
				rneg = dxy_q[63] ^ cd_q[31];
			end
			ST_MUL_DY: begin
				mul_start = cmd.go;
				mul_a = abs64(dxy_q);
				mul_b = abs32(sd_q);
				rneg = ~(dxy_q[63] ^ sd_q[31]);
			end
			ST_DIV_RED2: begin
				red_start = cmd.go;
				red_in = abs64(64'(acc_h_q));
				rneg = acc_h_q[31];
			end
			ST_COR2: cor_start = cmd.go;
			ST_MUL_CTDX: begin
				mul_start = cmd.go;
				mul_a = abs64(dx_q);
				mul_b = abs32(ct_q);
				rneg = dx_q[63] ^ ct_q[31];
			end
			ST_MUL_STDY: begin
				mul_start = cmd.go;
				mul_a = abs64(dy_q);
				mul_b = abs32(st_q);
				rneg = dy_q[63] ^ st_q[31];
			end
			ST_MUL_STDX: begin
				mul_start = cmd.go;
				mul_a = abs64(dx_q);
				mul_b = abs32(st_q);
				rneg = dx_q[63] ^ st_q[31];
			end
			ST_MUL_CTDY: begin
				mul_start = cmd.go;
				mul_a = abs64(dy_q);
				mul_b = abs32(ct_q);
				rneg = dy_q[63] ^ ct_q[31];
			end
			ST_MUL_LV: begin
				mul_start = cmd.go;
				mul_a = abs64(dxy_q);
				mul_b = USEC_PER_S;
			end
			ST_DIV_LV: begin
				div_start = cmd.go;
				div_num = t_q + 64'(dt_q >> 1);
				div_den = 32'(dt_q);
				rneg = dxy_q[63];
			end
			ST_MUL_AV: begin
				mul_start = cmd.go;
				mul_a = abs64(dth_q);
				mul_b = USEC_PER_S;
			end
			ST_DIV_AV: begin
				div_start = cmd.go;
				div_num = t_q + 64'(dt_sh >> 1);
				div_den = dt_sh;
				rneg = dth_q[63];
			end
			default: ;
		endcase
	end

	ddo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.done   (mul_done)
	);

	ddo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (quo),
		.done   (div_done)
	);

	ddo_cordic #(
		.TRIG_STEPS (TRIG_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.ang     (red_q),
		.cos_q24 (cor_c),
		.sin_q24 (cor_s),
		.done    (cor_done)
	);

	// 2*pi reduction: compare and subtract 2*pi << k, k from RED_TOP down to 0
	assign red_sub = 64'(TWO_PI_Q28) << red_k_q;
	assign red_s   = apply_sign(red_m_q, rneg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_busy_q <= 1'b0;
			red_done_q <= 1'b0;
			red_k_q    <= '0;
		end else begin
			red_done_q <= 1'b0;
			if (red_start) begin
				red_busy_q <= 1'b1;
				red_k_q    <= RED_TOP;
			end else if (red_busy_q) begin
				red_k_q <= red_k_q - 3'd1;
				if (red_k_q == 3'd0) begin
					red_busy_q <= 1'b0;
					red_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (red_start)
			red_m_q <= red_in;
		else if (red_busy_q && red_m_q >= red_sub)
			red_m_q <= red_m_q - red_sub;
	end

	assign stat.done = mul_done | div_done | cor_done | red_done_q;

	// rounding on magnitudes, half away from zero
	assign k_hi    = prod[95:32];
	assign dist_m  = (k_hi + (64'd1 << (RS - 1))) >> RS;
	assign gain_m  = 64'((prod + 96'd2048) >> 12);
	assign rot_m   = 64'((prod + (96'd1 << 23)) >> 24);
	assign mprod_s = apply_sign(prod[63:0], rneg);
	assign quo_s   = apply_sign(quo, rneg);
	assign rv      = (cmd.step == ST_MUL_STDY) ? p1_q - mprod_s : p1_q + mprod_s;
	assign rv_m    = (abs64(rv) + (64'd1 << 23)) >> 24;
	assign rv_r    = apply_sign(rv_m, rv[63]);
	assign acc_sel = (cmd.step == ST_MUL_STDY) ? acc_x_q : acc_y_q;
	assign acc_sum = 64'(acc_sel) + rv_r;
	assign nh0     = 64'(acc_h_q) + dth_q;
	assign nh1     = (nh0 >= TWO_S) ? nh0 - TWO_S : nh0;
	assign nh2     = (nh1 <= -TWO_S) ? nh1 + TWO_S : nh1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_lf_q  <= GAIN_RST;
			g_lr_q  <= GAIN_RST;
			g_ap_q  <= GAIN_RST;
			g_an_q  <= GAIN_RST;
			diam_q  <= DIAM_RST;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_h_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LIN_FWD: g_lf_q <= cfg_data[15:0];
					REG_LIN_REV: g_lr_q <= cfg_data[15:0];
					REG_ANG_POS: g_ap_q <= cfg_data[15:0];
					REG_ANG_NEG: g_an_q <= cfg_data[15:0];
					REG_DIAM:    diam_q <= cfg_data;
					default: ;
				endcase
			end
			if (stat.done && cmd.step == ST_MUL_STDY)
				acc_x_q <= sat32(acc_sum);
			if (stat.done && cmd.step == ST_MUL_CTDY) begin
				acc_y_q <= sat32(acc_sum);
				acc_h_q <= sat32(nh2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q  <= 17'(left_rpm) + 17'(right_rpm);
			dt_q   <= step_time_us;
			deg_q  <= yaw_degrees;
			stop_q <= (left_rpm == 16'sd0) && (right_rpm == 16'sd0);
		end
		if (stat.done) begin
			case (cmd.step)
				ST_MUL_SD, ST_MUL_DIAM, ST_MUL_DEG, ST_MUL_LV, ST_MUL_AV: t_q <= prod[63:0];
				ST_MUL_K:    dxy_q <= apply_sign(dist_m, sum_q[16]);
				ST_MUL_LG:   dxy_q <= apply_sign(gain_m, dxy_q[63]);
				ST_DIV_180:
					dth_q <= apply_sign(t_q + (prod[63:0] >> DEG_RSH), rneg) - 64'(acc_h_q);
				ST_MUL_AG:   dth_q <= apply_sign(gain_m, dth_q[63]);
				ST_DIV_RED1, ST_DIV_RED2: red_q <= red_s[31:0];
				ST_COR1: begin
					cd_q <= cor_c;
					sd_q <= cor_s;
				end
				ST_COR2: begin
					ct_q <= cor_c;
					st_q <= cor_s;
				end
				ST_MUL_DX:   dx_q <= apply_sign(rot_m, rneg);
				ST_MUL_DY:   dy_q <= apply_sign(rot_m, rneg);
				ST_MUL_CTDX, ST_MUL_STDX: p1_q <= mprod_s;
				ST_DIV_LV:   lv_q <= (dt_q == 20'd0) ? 32'sd0 : sat32(quo_s);
				ST_DIV_AV:   av_q <= (dt_q == 20'd0) ? 32'sd0 : sat32(quo_s);
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			pos_x_q   <= acc_x_q;
			pos_y_q   <= acc_y_q;
			heading_q <= acc_h_q;
			lin_vel_q <= lv_q;
			ang_vel_q <= av_q;
			stopped_q <= stop_q;
		end
	end

	assign pos_x   = pos_x_q;
	assign pos_y   = pos_y_q;
	assign heading = heading_q;
	assign lin_vel = lin_vel_q;
	assign ang_vel = ang_vel_q;
	assign stopped = stopped_q;
endmodule

// ----- hdl/ddo_ctrl.sv -----
// Controller: sequences the update through the shared arithmetic units.
module ddo_ctrl
	import ddo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ddo_stat_t stat,
	output ddo_cmd_t  cmd
);
	state_t state_q, state_d;
	logic   issued_q;
	logic   ov_q;
	logic   work;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_MUL_SD;
			ST_MUL_SD:   if (stat.done) state_d = ST_MUL_DIAM;
			ST_MUL_DIAM: if (stat.done) state_d = ST_MUL_K;
			ST_MUL_K:    if (stat.done) state_d = ST_MUL_LG;
			ST_MUL_LG:   if (stat.done) state_d = ST_MUL_DEG;
			ST_MUL_DEG:  if (stat.done) state_d = ST_DIV_180;
			ST_DIV_180:  if (stat.done) state_d = ST_MUL_AG;
			ST_MUL_AG:   if (stat.done) state_d = ST_DIV_RED1;
			ST_DIV_RED1: if (stat.done) state_d = ST_COR1;
			ST_COR1:     if (stat.done) state_d = ST_MUL_DX;
			ST_MUL_DX:   if (stat.done) state_d = ST_MUL_DY;
			ST_MUL_DY:   if (stat.done) state_d = ST_DIV_RED2;
			ST_DIV_RED2: if (stat.done) state_d = ST_COR2;
			ST_COR2:     if (stat.done) state_d = ST_MUL_CTDX;
			ST_MUL_CTDX: if (stat.done) state_d = ST_MUL_STDY;
			ST_MUL_STDY: if (stat.done) state_d = ST_MUL_STDX;
			ST_MUL_STDX: if (stat.done) state_d = ST_MUL_CTDY;
			ST_MUL_CTDY: if (stat.done) state_d = ST_MUL_LV;
			ST_MUL_LV:   if (stat.done) state_d = ST_DIV_LV;
			ST_DIV_LV:   if (stat.done) state_d = ST_MUL_AV;
			ST_MUL_AV:   if (stat.done) state_d = ST_DIV_AV;
			ST_DIV_AV:   if (stat.done) state_d = ST_FIN;
			ST_FIN:      if (!ov_q || out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		work         = (state_q != ST_IDLE) && (state_q != ST_FIN);
		in_ready     = (state_q == ST_IDLE);
		out_valid    = ov_q;
		cmd.step     = state_q;
		cmd.go       = work && !issued_q;
		cmd.load     = in_ready && in_valid;
		cmd.out_load = (state_q == ST_FIN) && (!ov_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			issued_q <= work && !stat.done;
			if (cmd.out_load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end
endmodule

// ----- hdl/diff_drive_odometry_gyro.sv -----
// Top level: differential-drive odometry with gyro heading.
//
//   channel  dir  beat contents
//   upd      in   left_rpm, right_rpm, step_time_us, yaw_degrees
//   pose     out  pos_x, pos_y, heading, lin_vel, ang_vel, stopped
//   cfg      in   index, data (register write, always ready)
//
// One update runs through the bit-serial multiplier (15 products), the 64-step divider
// (2 divides), the 6-step 2*pi reduction (2 reductions) and the CORDIC (2 rotations).
// One update is in work at a time; upd is ready only between updates.
// The finished beat sits in an output register, so the next update runs while it waits.
// Reset clears pose state and loads the register defaults; no clearing pass.
module diff_drive_odometry_gyro
	import ddo_pkg::*;
#(
	parameter int TRIG_STEPS    = TRIG_STEPS_DEF,
	parameter int POS_FRAC_BITS = POS_FRAC_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ddo_upd_if.sink    upd,
	ddo_pose_if.source pose,
	ddo_cfg_if.sink    cfg
);
	ddo_cmd_t  cmd;
	ddo_stat_t stat;

	assign cfg.ready = 1'b1;

	ddo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (upd.valid),
		.in_ready  (upd.ready),
		.out_valid (pose.valid),
		.out_ready (pose.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ddo_dp #(
		.TRIG_STEPS    (TRIG_STEPS),
		.POS_FRAC_BITS (POS_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.left_rpm     (upd.left_rpm),
		.right_rpm    (upd.right_rpm),
		.step_time_us (upd.step_time_us),
		.yaw_degrees  (upd.yaw_degrees),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.pos_x        (pose.pos_x),
		.pos_y        (pose.pos_y),
		.heading      (pose.heading),
		.lin_vel      (pose.lin_vel),
		.ang_vel      (pose.ang_vel),
		.stopped      (pose.stopped)
	);
endmodule

// ----- verif/diff_drive_odometry_gyro_test.sv -----
// Self-checking bench for the odometry block: computed pose per update vs. DUT output beats.
`timescale 1ns / 100ps

module diff_drive_odometry_gyro_test;
	import ddo_pkg::*;

	localparam longint K_PI      = longint'(PI_Q28);
	localparam longint K_TWO_PI  = longint'(TWO_PI_Q28);
	localparam longint K_HALF_PI = longint'(HALF_PI_Q28);
	localparam longint K_CORDIC  = longint'(CORDIC_K_Q28);
	localparam longint K_DIST    = longint'(DIST_K);
	localparam int     N_STEPS   = 16;
	localparam longint ANGLE_TBL [16] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
		2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192};

	typedef struct {
		int x;
		int y;
		int hdg;
		int lv;
		int av;
		bit stop;
	} pose_t;

	logic clk;
	logic arst_n;
	ddo_upd_if  upd();
	ddo_pose_if pose();
	ddo_cfg_if  cfg();

	diff_drive_odometry_gyro dut (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.pose   (pose),
		.cfg    (cfg)
	);

	longint gain_fwd, gain_rev, gain_pos, gain_neg, diam;
	longint odo_x, odo_y, odo_hdg;
	pose_t  pose_q[$];
	bit     upd_took, cfg_took;
	int     burst_left;
	int     stall_left = 0;
	int     rx_cycle = 0;
	int     errors = 0;

	always #6 clk = ~clk;

	function automatic longint rnd_shr(longint v, int s);
		longint unsigned m;
		m = v < 0 ? -v : v;
		m = (m + (64'd1 << (s - 1))) >> s;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint rnd_div(longint n, longint unsigned d);
		longint unsigned m;
		m = n < 0 ? -n : n;
		m = (m + d / 2) / d;
		return n < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// cos/sin of a Q28 angle, Q24 out
	task automatic cordic(input longint a, output longint c, output longint s);
		longint r, x, y, nx;
		bit neg;
		r = a % K_TWO_PI;
		x = K_CORDIC;
		y = 0;
		neg = 0;
		if (r > K_PI) r -= K_TWO_PI;
		if (r < -K_PI) r += K_TWO_PI;
		if (r > K_HALF_PI) begin
			r -= K_PI;
			neg = 1;
		end else if (r < -K_HALF_PI) begin
			r += K_PI;
			neg = 1;
		end
		for (int i = 0; i < N_STEPS; i++) begin
			if (r >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				r -= ANGLE_TBL[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				r += ANGLE_TBL[i];
			end
			x = nx;
		end
		if (neg) begin
			x = -x;
			y = -y;
		end
		c = rnd_shr(x, 4);
		s = rnd_shr(y, 4);
	endtask

	task automatic advance_pose(input longint l, input longint r, input longint unsigned dt,
			input longint deg, output pose_t res);
		longint sum, travel, gyro, dth, nh, ct, st, cd, sd, dx, dy, lv, av;
		longint unsigned mag, p, lo, hi;
		sum = l + r;
		mag = sum < 0 ? -sum : sum;
		p = mag * dt * longint'(diam);
		lo = (p & 64'hFFFFFFFF) * longint'(K_DIST);
		hi = (p >> 32) * longint'(K_DIST) + (lo >> 32);
		hi = (hi + (64'd1 << 31)) >> 32;
		travel = sum < 0 ? -longint'(hi) : longint'(hi);
		if (travel > 0) travel = rnd_shr(travel * gain_fwd, 12);
		else if (travel < 0) travel = rnd_shr(travel * gain_rev, 12);
		gyro = rnd_div(deg * K_PI, 180);
		dth = gyro - odo_hdg;
		if (dth > 0) dth = rnd_shr(dth * gain_pos, 12);
		else if (dth < 0) dth = rnd_shr(dth * gain_neg, 12);
		cordic(dth, cd, sd);
		dx = rnd_shr(cd * travel, 24);
		dy = -rnd_shr(sd * travel, 24);
		cordic(odo_hdg, ct, st);
		odo_x = clamp32(odo_x + rnd_shr(ct * dx - st * dy, 24));
		odo_y = clamp32(odo_y + rnd_shr(st * dx + ct * dy, 24));
		nh = odo_hdg + dth;
		if (nh >= K_TWO_PI) nh -= K_TWO_PI;
		if (nh <= -K_TWO_PI) nh += K_TWO_PI;
		odo_hdg = clamp32(nh);
		lv = 0;
		av = 0;
		if (dt != 0) begin
			lv = clamp32(rnd_div(travel * 1000000, dt));
			av = clamp32(rnd_div(dth * 1000000, dt << 12));
		end
		res.x = int'(odo_x);
		res.y = int'(odo_y);
		res.hdg = int'(odo_hdg);
		res.lv = int'(lv);
		res.av = int'(av);
		res.stop = (l == 0 && r == 0);
	endtask

	// accepted beats on the input side: config and updates
	always @(posedge clk) begin
		pose_t res;
		upd_took = upd.valid && upd.ready;
		cfg_took = cfg.valid && cfg.ready;
		if (cfg_took) begin
			case (reg_idx_t'(cfg.index))
				REG_LIN_FWD: gain_fwd = cfg.data & 20'hFFFF;
				REG_LIN_REV: gain_rev = cfg.data & 20'hFFFF;
				REG_ANG_POS: gain_pos = cfg.data & 20'hFFFF;
				REG_ANG_NEG: gain_neg = cfg.data & 20'hFFFF;
				REG_DIAM:    diam     = cfg.data;
				default: ;
			endcase
		end
		if (upd_took) begin
			advance_pose(upd.left_rpm, upd.right_rpm, upd.step_time_us, upd.yaw_degrees, res);
			pose_q.push_back(res);
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		pose_t want;
		if (pose.valid && pose.ready) begin
			if (pose_q.size() == 0) begin
				$display("%0t unexpected pose beat: expected none actual x=%0d", $time, pose.pos_x);
				errors++;
			end else begin
				want = pose_q.pop_front();
				check_field("pos_x", want.x, pose.pos_x);
				check_field("pos_y", want.y, pose.pos_y);
				check_field("heading", want.hdg, pose.heading);
				check_field("lin_vel", want.lv, pose.lin_vel);
				check_field("ang_vel", want.av, pose.ang_vel);
				check_field("stopped", want.stop, pose.stopped);
			end
		end
	end

	// receiver stall pattern: quiet windows alternate with random stalls
	always @(negedge clk) begin
		rx_cycle++;
		if (!arst_n || (rx_cycle % 6000) < 1500) begin
			pose.ready = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			pose.ready = 1'b0;
		end else begin
			pose.ready = 1'b1;
			if ($urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 1200);
		end
	end

	task automatic send_update(input logic signed [15:0] l, input logic signed [15:0] r,
			input logic [19:0] dt, input logic signed [9:0] deg);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 900)) @(negedge clk);
		end
		burst_left--;
		upd.left_rpm = l;
		upd.right_rpm = r;
		upd.step_time_us = dt;
		upd.yaw_degrees = deg;
		upd.valid = 1'b1;
		do @(negedge clk); while (!upd_took);
		upd.valid = 1'b0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [19:0] val);
		cfg.index = idx;
		cfg.data = val;
		cfg.valid = 1'b1;
		do @(negedge clk); while (!cfg_took);
		cfg.valid = 1'b0;
	endtask

	task automatic wait_drained;
		while (pose_q.size() != 0) @(negedge clk);
	endtask

	task automatic send_random_update;
		logic signed [15:0] l, r;
		logic [19:0] dt;
		logic signed [9:0] deg;
		case ($urandom_range(0, 3))
			0: begin
				l = 16'($urandom);
				r = 16'($urandom);
			end
			1: begin
				l = $signed(16'($urandom_range(0, 400))) - 16'sd200;
				r = $signed(16'($urandom_range(0, 400))) - 16'sd200;
			end
			2: begin
				l = 16'($urandom);
				r = l;
			end
			default: begin
				l = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom);
				r = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom);
			end
		endcase
		case ($urandom_range(0, 9))
			0: dt = 20'd0;
			1, 2, 3: dt = 20'($urandom);
			default: dt = 20'($urandom_range(1, 200000));
		endcase
		if ($urandom_range(0, 7) == 0)
			deg = 10'($urandom);
		else
			deg = $signed(10'($urandom_range(0, 720))) - 10'sd360;
		send_update(l, r, dt, deg);
	endtask

	task automatic test_directed;
		send_update(16'sd0, 16'sd0, 20'd0, 10'sd0);
		send_update(16'sd32767, 16'sd32767, 20'd1048575, 10'sd0);
		send_update(-16'sd32768, -16'sd32768, 20'd1048575, 10'sd0);
		send_update(16'sd32767, -16'sd32768, 20'd1000, 10'sd90);
		send_update(16'sd160, 16'sd160, 20'd0, 10'sd45);
		send_update(16'sd160, 16'sd160, 20'd100000, 10'sd360);
		send_update(16'sd160, -16'sd160, 20'd100000, -10'sd360);
		send_update(16'sd0, 16'sd16, 20'd1, 10'sd180);
		send_update(-16'sd16, 16'sd0, 20'd1, -10'sd180);
		send_update(16'sd100, 16'sd100, 20'd50000, 10'sd511);
		send_update(16'sd100, 16'sd100, 20'd50000, -10'sd512);
		send_update(16'sd1, 16'sd0, 20'd1048575, 10'sd1);
		send_update(16'sd0, 16'sd0, 20'd1048575, -10'sd1);
		send_update(16'sd32767, 16'sd32767, 20'd1048575, 10'sd270);
		send_update(16'sd32767, 16'sd32767, 20'd1048575, -10'sd90);
		send_update(-16'sd32768, -16'sd32768, 20'd1048575, 10'sd0);
		send_update(16'sd4, 16'sd4, 20'd20000, 10'sd0);
	endtask

	task automatic test_reg_extremes;
		wait_drained();
		write_reg(REG_LIN_FWD, 20'd0);
		write_reg(REG_LIN_REV, 20'd0);
		write_reg(REG_ANG_POS, 20'd0);
		write_reg(REG_ANG_NEG, 20'd0);
		write_reg(REG_DIAM, 20'd0);
		send_update(16'sd500, 16'sd500, 20'd100000, 10'sd90);
		send_update(-16'sd500, -16'sd500, 20'd100000, -10'sd90);
		wait_drained();
		write_reg(REG_LIN_FWD, 20'hFFFFF);
		write_reg(REG_LIN_REV, 20'd65535);
		write_reg(REG_ANG_POS, 20'd65535);
		write_reg(REG_ANG_NEG, 20'hFFFFF);
		write_reg(REG_DIAM, 20'd1048575);
		send_update(16'sd32767, 16'sd32767, 20'd1048575, 10'sd360);
		send_update(-16'sd32768, -16'sd32768, 20'd1048575, -10'sd360);
		send_update(16'sd200, 16'sd300, 20'd1, 10'sd10);
		wait_drained();
		write_reg(REG_DIAM, 20'd1);
		write_reg(REG_ANG_POS, 20'd1);
		write_reg(REG_ANG_NEG, 20'd1);
		send_update(16'sd32767, 16'sd32767, 20'd1048575, 10'sd180);
		send_update(-16'sd32768, 16'sd0, 20'd7, -10'sd180);
		wait_drained();
		write_reg(REG_LIN_FWD, GAIN_RST);
		write_reg(REG_LIN_REV, GAIN_RST);
		write_reg(REG_ANG_POS, GAIN_RST);
		write_reg(REG_ANG_NEG, GAIN_RST);
		write_reg(REG_DIAM, 20'd1000000);
		send_update(16'sd1000, 16'sd1000, 20'd100000, 10'sd30);
	endtask

	task automatic test_random;
		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			if (ph != 0) begin
				write_reg(REG_LIN_FWD,
					20'($urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 8192)));
				write_reg(REG_LIN_REV,
					20'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8192)));
				write_reg(REG_ANG_POS, 20'($urandom));
				write_reg(REG_ANG_NEG, 20'($urandom_range(0, 8192)));
				write_reg(REG_DIAM, 20'(ph == 4 ? 1048575 : $urandom_range(1, 1000000)));
			end
			for (int n = 0; n < 110; n++) begin
				if (n == 55)
					wait_drained();
				send_random_update();
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		upd.valid = 1'b0;
		upd.left_rpm = '0;
		upd.right_rpm = '0;
		upd.step_time_us = '0;
		upd.yaw_degrees = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_LIN_FWD;
		cfg.data = '0;
		gain_fwd = GAIN_RST;
		gain_rev = GAIN_RST;
		gain_pos = GAIN_RST;
		gain_neg = GAIN_RST;
		diam = DIAM_RST;
		odo_x = 0;
		odo_y = 0;
		odo_hdg = 0;
		burst_left = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_reg_extremes();
		test_random();
		wait_drained();
		repeat (900) @(negedge clk);
		if (errors == 0 && pose_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0t %0d mismatches, %0d poses outstanding", $time, errors, pose_q.size());
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#80ms;
		$display("%0t timeout, %0d poses outstanding", $time, pose_q.size());
		$display("FAIL");
		$finish;
	end

endmodule
